/* hdl/epl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_pkg
// shared types, codes and helpers of the energy plan table
// ----------------------------------------------------------------------------
package epl_pkg;

    localparam int DIV_BITS  = 43;
    localparam int SEC_PER_H = 3600;
    localparam int RES_MAX   = 4;

    localparam logic [3:0] ACT_ALLOC_E  = 4'd0;
    localparam logic [3:0] ACT_ALLOC_T  = 4'd1;
    localparam logic [3:0] ACT_SET_E    = 4'd2;
    localparam logic [3:0] ACT_SET_T    = 4'd3;
    localparam logic [3:0] ACT_ADJUST   = 4'd4;
    localparam logic [3:0] ACT_SELECT   = 4'd5;
    localparam logic [3:0] ACT_REPORT   = 4'd6;
    localparam logic [3:0] ACT_CLEAR    = 4'd7;
    localparam logic [3:0] ACT_CLR_ALL  = 4'd8;
    localparam logic [3:0] ACT_SET_PWR  = 4'd9;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_FREE   = 2'd1;
    localparam logic [1:0] STAT_BAD_SLOT  = 2'd2;
    localparam logic [1:0] STAT_NO_ACTIVE = 2'd3;

    typedef struct packed {
        logic [3:0]         action;
        logic [31:0]        now;
        logic [2:0]         slot;
        logic signed [31:0] amount_a;
        logic signed [31:0] amount_b;
        logic [31:0]        earliest_start;
        logic [31:0]        latest_end;
        logic               power_on;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  plan_slot;
        logic        has_plan;
        logic [31:0] start_in;
        logic [31:0] end_in;
        logic [31:0] min_time;
        logic [31:0] max_time;
        logic        power_state;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic        start;
        logic [30:0] wh;
        logic [15:0] power;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SETUP,
        S_U_LOAD,
        S_U_DREQ,
        S_U_DOPT,
        S_U_FIN1,
        S_U_FIN2,
        S_U_DONE,
        S_WALK,
        S_REP,
        S_EMIT,
        S_OUT
    } t_state;

    function automatic logic [30:0] add_energy(input logic [30:0] e,
                                               input logic signed [31:0] d);
        logic signed [33:0] s;
        s = $signed({3'b000, e}) + 34'(d);
        if (s <= 34'sd0) begin
            return 31'd0;
        end else if (s > 34'sh7FFF_FFFF) begin
            return '1;
        end
        return s[30:0];
    endfunction

    function automatic logic [31:0] until_t(input logic [31:0] t, input logic [31:0] now);
        return (t > now) ? (t - now) : 32'd0;
    endfunction

endpackage

/* hdl/epl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_in_if
// input word channel of the energy plan table
// ----------------------------------------------------------------------------
interface epl_in_if;
    logic              valid;
    logic              ready;
    epl_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/epl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_out_if
// result word channel of the energy plan table
// ----------------------------------------------------------------------------
interface epl_out_if;
    logic               valid;
    logic               ready;
    epl_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/epl_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_cfg_if
// configuration write channel carrying the load power
// ----------------------------------------------------------------------------
interface epl_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/epl_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_div
// serial restoring divider: wh * 3600 / power, one quotient bit per cycle,
// result saturated to 32 bits
// ----------------------------------------------------------------------------
module epl_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epl_pkg::t_div_req   i_req,
    output epl_pkg::t_div_rsp   o_rsp
);

    localparam int CW = $clog2(epl_pkg::DIV_BITS);

    logic                         r_busy;
    logic                         r_done;
    logic [CW-1:0]                r_cnt;
    logic [epl_pkg::DIV_BITS-1:0] r_dvd;
    logic [16:0]                  r_rem;
    logic [15:0]                  r_div;
    logic [16:0]                  rem_sh;
    logic [16:0]                  rem_sub;

    assign rem_sh  = {r_rem[15:0], r_dvd[epl_pkg::DIV_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(epl_pkg::DIV_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= epl_pkg::DIV_BITS'(i_req.wh) * epl_pkg::DIV_BITS'(epl_pkg::SEC_PER_H);
            r_rem <= '0;
            r_div <= i_req.power;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_div}) begin
                r_rem <= rem_sub;
                r_dvd <= {r_dvd[epl_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_dvd <= {r_dvd[epl_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (|r_dvd[epl_pkg::DIV_BITS-1:32]) ? 32'hFFFF_FFFF : r_dvd[31:0];

endmodule

/* hdl/energy_plan_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_plan_table_unit
// table of run plans for a switched load with a shared serial divider
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one command word; i_in.ready is high only while the block
//   is idle. o_out returns one to four result words per command, the final
//   one flagged by last. i_cfg writes the load power at any time; it is used
//   by the next plan that is set up.
//   an energy based plan update with a nonzero load power runs two 43-step
//   divisions on the one shared divider; a time based update uses no division.
//   report walks all used plans, and select walks all plans when no active
//   plan is still live.
//   a stalled receiver holds the result word in the output register and the
//   sequencer waits; no command is taken until the last word has gone.
//   reset (synchronous, active low) empties the table, drops the active plan,
//   turns the load off and sets the load power to zero.
// ----------------------------------------------------------------------------
module energy_plan_table_unit #(
    parameter int PLAN_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    epl_in_if.sink    i_in,
    epl_out_if.source o_out,
    epl_cfg_if.sink   i_cfg
);

    localparam int IW = (PLAN_COUNT > 1) ? $clog2(PLAN_COUNT) : 1;
    localparam int PW = $clog2(PLAN_COUNT + 1);

    epl_pkg::t_state    r_state, n_state;
    epl_pkg::t_in_word  r_in;
    epl_pkg::t_out_word r_od;
    epl_pkg::t_div_req  div_req;
    epl_pkg::t_div_rsp  div_rsp;

    logic [PLAN_COUNT-1:0] r_used;
    logic                  r_tb    [PLAN_COUNT];
    logic [31:0]           r_start [PLAN_COUNT];
    logic [31:0]           r_end   [PLAN_COUNT];
    logic [15:0]           r_power [PLAN_COUNT];
    logic [30:0]           r_req   [PLAN_COUNT];
    logic [30:0]           r_opt   [PLAN_COUNT];
    logic [31:0]           r_min_t [PLAN_COUNT];
    logic [31:0]           r_max_t [PLAN_COUNT];
    logic [31:0]           r_last_t[PLAN_COUNT];

    logic          r_act_v;
    logic [IW-1:0] r_act_idx;
    logic          r_load_on;
    logic [15:0]   r_maxc;

    logic [IW-1:0]      r_idx;
    logic [PW-1:0]      r_pos;
    logic [2:0]         r_cnt;
    logic signed [31:0] r_dr, r_dop;
    logic               r_pwr;
    logic               r_ok;
    logic               r_phase;
    logic               r_best_v;
    logic [IW-1:0]      r_best_idx;
    logic [31:0]        r_best_start;
    logic [31:0]        r_min, r_max, r_left;
    logic [1:0]         r_estat;
    logic [2:0]         r_eslot;
    logic               r_eplan;
    logic               r_elast;
    logic               r_rep;
    logic               r_ov;

    logic          free_v;
    logic [IW-1:0] free_idx;
    logic          slot_ok;
    logic [IW-1:0] pos_idx;
    logic          pos_end;
    logic          more_used;
    logic [30:0]   req_new, opt_new;
    logic [31:0]   dt;
    logic [31:0]   cap_max, cap_min;
    logic          has_emit;
    logic          energy_act;

    epl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // free slot search and index helpers
    always_comb begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = PLAN_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_v   = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        more_used = 1'b0;
        for (int j = 0; j < PLAN_COUNT; j++) begin
            if ((PW'(j) > r_pos) && r_used[j]) begin
                more_used = 1'b1;
            end
        end
    end

    assign slot_ok    = ({1'b0, r_in.slot} < 4'(PLAN_COUNT));
    assign pos_idx    = r_pos[IW-1:0];
    assign pos_end    = (r_pos == PW'(PLAN_COUNT));
    assign energy_act = (r_in.action == epl_pkg::ACT_ALLOC_E) ||
                        (r_in.action == epl_pkg::ACT_SET_E);
    assign req_new    = epl_pkg::add_energy(r_req[r_idx], r_dr);
    assign opt_new    = epl_pkg::add_energy(r_opt[r_idx], r_dop);
    assign dt         = r_in.now - r_last_t[r_idx];
    assign cap_max    = (r_max > r_left) ? r_left : r_max;
    assign cap_min    = (r_min > cap_max) ? cap_max : r_min;
    assign has_emit   = r_eplan && r_used[r_idx];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epl_pkg::S_IDLE: begin
                if (i_in.valid) n_state = epl_pkg::S_DISPATCH;
            end
            epl_pkg::S_DISPATCH: begin
                unique case (r_in.action) inside
                    epl_pkg::ACT_ALLOC_E, epl_pkg::ACT_ALLOC_T: begin
                        n_state = free_v ? epl_pkg::S_SETUP : epl_pkg::S_EMIT;
                    end
                    epl_pkg::ACT_SET_E, epl_pkg::ACT_SET_T: begin
                        n_state = slot_ok ? epl_pkg::S_SETUP : epl_pkg::S_EMIT;
                    end
                    epl_pkg::ACT_ADJUST: begin
                        n_state = r_act_v ? epl_pkg::S_U_LOAD : epl_pkg::S_EMIT;
                    end
                    epl_pkg::ACT_SELECT: begin
                        n_state = r_act_v ? epl_pkg::S_U_LOAD : epl_pkg::S_WALK;
                    end
                    epl_pkg::ACT_REPORT: n_state = epl_pkg::S_WALK;
                    default:             n_state = epl_pkg::S_EMIT;
                endcase
            end
            epl_pkg::S_SETUP: n_state = epl_pkg::S_U_LOAD;
            epl_pkg::S_U_LOAD: begin
                if (!r_used[r_idx]) begin
                    n_state = epl_pkg::S_U_DONE;
                end else if (!r_tb[r_idx] && (r_power[r_idx] != 16'd0)) begin
                    n_state = epl_pkg::S_U_DREQ;
                end else begin
                    n_state = epl_pkg::S_U_FIN1;
                end
            end
            epl_pkg::S_U_DREQ: begin
                if (div_rsp.done) n_state = epl_pkg::S_U_DOPT;
            end
            epl_pkg::S_U_DOPT: begin
                if (div_rsp.done) n_state = epl_pkg::S_U_FIN1;
            end
            epl_pkg::S_U_FIN1: n_state = epl_pkg::S_U_FIN2;
            epl_pkg::S_U_FIN2: n_state = epl_pkg::S_U_DONE;
            epl_pkg::S_U_DONE: begin
                unique case (r_in.action) inside
                    epl_pkg::ACT_SELECT: begin
                        n_state = (!r_phase && r_ok) ? epl_pkg::S_EMIT : epl_pkg::S_WALK;
                    end
                    epl_pkg::ACT_REPORT: n_state = epl_pkg::S_WALK;
                    default:             n_state = epl_pkg::S_EMIT;
                endcase
            end
            epl_pkg::S_WALK: begin
                if (pos_end) begin
                    n_state = (r_in.action == epl_pkg::ACT_SELECT) ?
                              epl_pkg::S_EMIT : epl_pkg::S_REP;
                end else if ((r_in.action == epl_pkg::ACT_SELECT) || r_used[pos_idx]) begin
                    n_state = epl_pkg::S_U_LOAD;
                end
            end
            epl_pkg::S_REP: begin
                if (pos_end) begin
                    n_state = (r_cnt == 3'd0) ? epl_pkg::S_EMIT : epl_pkg::S_IDLE;
                end else if (r_used[pos_idx] && (r_cnt < 3'(epl_pkg::RES_MAX))) begin
                    n_state = epl_pkg::S_EMIT;
                end
            end
            epl_pkg::S_EMIT: n_state = epl_pkg::S_OUT;
            epl_pkg::S_OUT: begin
                if (o_out.ready) n_state = r_rep ? epl_pkg::S_REP : epl_pkg::S_IDLE;
            end
            default: n_state = epl_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        epl_pkg::t_out_word w;
        w             = r_od;
        w.power_state = r_load_on;
        o_out.data    = w;
        o_out.valid   = r_ov;
        i_in.ready    = (r_state == epl_pkg::S_IDLE);
        i_cfg.ready   = 1'b1;
        div_req.start = ((r_state == epl_pkg::S_U_LOAD) && r_used[r_idx] && !r_tb[r_idx] &&
                         (r_power[r_idx] != 16'd0)) ||
                        ((r_state == epl_pkg::S_U_DREQ) && div_rsp.done);
        div_req.wh    = (r_state == epl_pkg::S_U_LOAD) ? req_new : r_opt[r_idx];
        div_req.power = r_power[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxc <= 16'd0;
        end else if (i_cfg.valid) begin
            r_maxc <= i_cfg.data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_act_v   <= 1'b0;
            r_act_idx <= '0;
            r_load_on <= 1'b0;
            r_ov      <= 1'b0;
            r_rep     <= 1'b0;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_phase   <= 1'b0;
            r_best_v  <= 1'b0;
            r_ok      <= 1'b0;
        end else begin
            unique case (r_state)
                epl_pkg::S_DISPATCH: begin
                    r_pos    <= '0;
                    r_cnt    <= '0;
                    r_phase  <= !r_act_v;
                    r_best_v <= 1'b0;
                    r_rep    <= 1'b0;
                    unique case (r_in.action) inside
                        epl_pkg::ACT_CLEAR: begin
                            if (slot_ok) r_used[r_in.slot[IW-1:0]] <= 1'b0;
                        end
                        epl_pkg::ACT_CLR_ALL: r_used    <= '0;
                        epl_pkg::ACT_SET_PWR: r_load_on <= r_in.power_on;
                        default: ;
                    endcase
                end
                epl_pkg::S_SETUP: r_used[r_idx] <= 1'b1;
                epl_pkg::S_U_LOAD: begin
                    if (!r_used[r_idx]) r_ok <= 1'b0;
                end
                epl_pkg::S_U_FIN2: begin
                    r_ok <= (cap_max != 32'd0);
                    if (cap_max == 32'd0) r_used[r_idx] <= 1'b0;
                end
                epl_pkg::S_U_DONE: begin
                    unique case (r_in.action) inside
                        epl_pkg::ACT_ALLOC_E, epl_pkg::ACT_ALLOC_T,
                        epl_pkg::ACT_SET_E, epl_pkg::ACT_SET_T: begin
                            if (!r_load_on) r_act_v <= 1'b0;
                        end
                        epl_pkg::ACT_ADJUST: begin
                            if (!r_ok) begin
                                r_load_on <= 1'b0;
                                r_act_v   <= 1'b0;
                            end
                        end
                        epl_pkg::ACT_SELECT: begin
                            if (!r_phase) begin
                                if (!r_ok) begin
                                    r_load_on <= 1'b0;
                                    r_act_v   <= 1'b0;
                                    r_phase   <= 1'b1;
                                end
                            end else begin
                                if (r_ok && (!r_best_v || (r_best_start > r_start[r_idx]))) begin
                                    r_best_v <= 1'b1;
                                end
                                r_pos <= r_pos + 1'b1;
                            end
                        end
                        epl_pkg::ACT_REPORT: begin
                            if (!r_ok && r_act_v && (r_act_idx == r_idx)) begin
                                r_load_on <= 1'b0;
                                r_act_v   <= 1'b0;
                            end
                            r_pos <= r_pos + 1'b1;
                        end
                        default: ;
                    endcase
                end
                epl_pkg::S_WALK: begin
                    if (pos_end) begin
                        if (r_in.action == epl_pkg::ACT_SELECT) begin
                            if (r_best_v) begin
                                r_act_v   <= 1'b1;
                                r_act_idx <= r_best_idx;
                            end
                        end else begin
                            r_pos <= '0;
                        end
                    end else if ((r_in.action != epl_pkg::ACT_SELECT) && !r_used[pos_idx]) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                epl_pkg::S_REP: begin
                    if (pos_end) begin
                        r_rep <= 1'b0;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        if (r_used[pos_idx] && (r_cnt < 3'(epl_pkg::RES_MAX))) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_rep <= 1'b1;
                        end
                    end
                end
                epl_pkg::S_EMIT: r_ov <= 1'b1;
                epl_pkg::S_OUT: begin
                    if (o_out.ready) r_ov <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            epl_pkg::S_IDLE: begin
                if (i_in.valid) r_in <= i_in.data;
            end
            epl_pkg::S_DISPATCH: begin
                r_dr    <= 32'sd0;
                r_dop   <= 32'sd0;
                r_pwr   <= r_load_on;
                r_eplan <= 1'b0;
                r_elast <= 1'b1;
                r_estat <= epl_pkg::STAT_OK;
                r_eslot <= 3'd0;
                unique case (r_in.action) inside
                    epl_pkg::ACT_ALLOC_E, epl_pkg::ACT_ALLOC_T: begin
                        r_idx <= free_idx;
                        r_pwr <= 1'b0;
                        if (!free_v) r_estat <= epl_pkg::STAT_NO_FREE;
                        if (r_in.action == epl_pkg::ACT_ALLOC_E) begin
                            r_dr  <= r_in.amount_a;
                            r_dop <= r_in.amount_b;
                        end
                    end
                    epl_pkg::ACT_SET_E, epl_pkg::ACT_SET_T: begin
                        r_idx <= r_in.slot[IW-1:0];
                        r_pwr <= 1'b0;
                        if (!slot_ok) begin
                            r_estat <= epl_pkg::STAT_BAD_SLOT;
                            r_eslot <= r_in.slot;
                        end
                        if (r_in.action == epl_pkg::ACT_SET_E) begin
                            r_dr  <= r_in.amount_a;
                            r_dop <= r_in.amount_b;
                        end
                    end
                    epl_pkg::ACT_ADJUST: begin
                        r_idx   <= r_act_idx;
                        r_dr    <= r_in.amount_a;
                        r_dop   <= r_in.amount_b;
                        r_estat <= epl_pkg::STAT_NO_ACTIVE;
                    end
                    epl_pkg::ACT_SELECT: r_idx <= r_act_idx;
                    epl_pkg::ACT_CLEAR: begin
                        r_eslot <= r_in.slot;
                        if (!slot_ok) r_estat <= epl_pkg::STAT_BAD_SLOT;
                    end
                    default: ;
                endcase
            end
            epl_pkg::S_SETUP: begin
                r_tb[r_idx]    <= !energy_act;
                r_start[r_idx] <= r_in.earliest_start;
                r_end[r_idx]   <= r_in.latest_end;
                r_power[r_idx] <= r_maxc;
                r_req[r_idx]   <= 31'd0;
                r_opt[r_idx]   <= 31'd0;
                r_min_t[r_idx] <= r_in.amount_a[31] ? 32'd0 : r_in.amount_a;
                r_max_t[r_idx] <= r_in.amount_b[31] ? 32'd0 : r_in.amount_b;
            end
            epl_pkg::S_U_LOAD: begin
                r_req[r_idx] <= req_new;
                r_opt[r_idx] <= opt_new;
                if (r_tb[r_idx]) begin
                    if (r_pwr) begin
                        r_min <= (r_min_t[r_idx] > dt) ? (r_min_t[r_idx] - dt) : 32'd0;
                        r_max <= (r_max_t[r_idx] > dt) ? (r_max_t[r_idx] - dt) : 32'd0;
                    end else begin
                        r_min <= r_min_t[r_idx];
                        r_max <= r_max_t[r_idx];
                    end
                end else begin
                    r_min <= 32'd0;
                    r_max <= 32'd0;
                end
            end
            epl_pkg::S_U_DREQ: begin
                if (div_rsp.done) r_min <= div_rsp.quot;
            end
            epl_pkg::S_U_DOPT: begin
                if (div_rsp.done) r_max <= div_rsp.quot;
            end
            epl_pkg::S_U_FIN1: begin
                r_left <= epl_pkg::until_t(r_end[r_idx], r_in.now);
                if (r_max < r_min) r_max <= r_min;
            end
            epl_pkg::S_U_FIN2: begin
                r_min_t[r_idx]  <= cap_min;
                r_max_t[r_idx]  <= cap_max;
                r_last_t[r_idx] <= r_in.now;
            end
            epl_pkg::S_U_DONE: begin
                r_elast <= 1'b1;
                if (r_in.action == epl_pkg::ACT_SELECT) begin
                    if (r_phase && r_ok &&
                        (!r_best_v || (r_best_start > r_start[r_idx]))) begin
                        r_best_idx   <= r_idx;
                        r_best_start <= r_start[r_idx];
                    end
                    r_estat <= epl_pkg::STAT_OK;
                    r_eslot <= 3'(r_idx);
                    r_eplan <= 1'b1;
                end else if ((r_in.action == epl_pkg::ACT_ADJUST) && !r_ok) begin
                    r_estat <= epl_pkg::STAT_NO_ACTIVE;
                    r_eslot <= 3'd0;
                    r_eplan <= 1'b0;
                end else begin
                    r_estat <= epl_pkg::STAT_OK;
                    r_eslot <= 3'(r_idx);
                    r_eplan <= 1'b1;
                end
            end
            epl_pkg::S_WALK: begin
                if (pos_end) begin
                    r_idx   <= r_best_idx;
                    r_elast <= 1'b1;
                    r_estat <= r_best_v ? epl_pkg::STAT_OK : epl_pkg::STAT_NO_ACTIVE;
                    r_eslot <= r_best_v ? 3'(r_best_idx) : 3'd0;
                    r_eplan <= r_best_v;
                end else begin
                    r_idx <= pos_idx;
                end
            end
            epl_pkg::S_REP: begin
                r_idx   <= pos_idx;
                r_estat <= epl_pkg::STAT_OK;
                if (pos_end) begin
                    r_eslot <= 3'd0;
                    r_eplan <= 1'b0;
                    r_elast <= 1'b1;
                end else begin
                    r_eslot <= 3'(pos_idx);
                    r_eplan <= 1'b1;
                    r_elast <= (r_cnt == 3'(epl_pkg::RES_MAX - 1)) || !more_used;
                end
            end
            epl_pkg::S_EMIT: begin
                r_od.status      <= r_estat;
                r_od.plan_slot   <= r_eslot;
                r_od.has_plan    <= has_emit;
                r_od.start_in    <= has_emit ? epl_pkg::until_t(r_start[r_idx], r_in.now) : 32'd0;
                r_od.end_in      <= has_emit ? epl_pkg::until_t(r_end[r_idx], r_in.now) : 32'd0;
                r_od.min_time    <= has_emit ? r_min_t[r_idx] : 32'd0;
                r_od.max_time    <= has_emit ? r_max_t[r_idx] : 32'd0;
                r_od.power_state <= r_load_on;
                r_od.last        <= r_elast;
            end
            default: ;
        endcase
    end

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a word is in work");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.has_plan) |->
        (o_out.data.min_time == 32'd0 && o_out.data.max_time == 32'd0 &&
         o_out.data.start_in == 32'd0 && o_out.data.end_in == 32'd0))
        else $error("result without plan carries plan fields");

    a_error_no_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.status != epl_pkg::STAT_OK)) |-> !o_out.data.has_plan)
        else $error("error result describes a plan");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == epl_pkg::S_U_DREQ || r_state == epl_pkg::S_U_DOPT))
        else $error("divider result outside a division wait");

endmodule

/* test/epl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epl_checker
// watches the command, result and load power channels of the energy plan
// table, keeps its own copy of the plan table and compares every result word
// ----------------------------------------------------------------------------
module epl_checker #(
    parameter int PLAN_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  epl_pkg::t_in_word i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  epl_pkg::t_out_word i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import epl_pkg::*;

    localparam int NP = PLAN_COUNT;

    logic        used [NP];
    logic        timed [NP];
    logic [31:0] t_start [NP];
    logic [31:0] t_end [NP];
    logic [15:0] pwr [NP];
    logic [30:0] e_req [NP];
    logic [30:0] e_opt [NP];
    logic [31:0] t_min [NP];
    logic [31:0] t_max [NP];
    logic [31:0] t_last [NP];
    logic        act_valid;
    int          act_idx;
    logic        load_on;
    logic [15:0] load_power;

    t_out_word   result_q[$];
    t_out_word   batch[$];

    function automatic logic [31:0] left_of(logic [31:0] t, logic [31:0] now);
        return (t > now) ? t - now : 32'd0;
    endfunction

    function automatic logic [30:0] energy_add(logic [30:0] e, logic signed [31:0] d);
        longint s;
        s = longint'(e) + longint'(d);
        if (s <= 0) return 31'd0;
        if (s > 64'h7FFF_FFFF) return 31'h7FFF_FFFF;
        return s[30:0];
    endfunction

    function automatic logic [31:0] wh_secs(logic [30:0] wh, logic [15:0] p);
        logic [63:0] q;
        q = (64'(wh) * 64'd3600) / 64'(p);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic wipe(int i);
        used[i] = 0; timed[i] = 0; t_start[i] = 0; t_end[i] = 0; pwr[i] = 0;
        e_req[i] = 0; e_opt[i] = 0; t_min[i] = 0; t_max[i] = 0; t_last[i] = 0;
    endtask

    task automatic refresh(input int i, input logic [31:0] now, input logic on,
                           input logic signed [31:0] dr, input logic signed [31:0] dop,
                           output logic alive);
        logic [31:0] dt;
        logic [31:0] lft;
        alive = 0;
        if (!used[i]) return;
        dt = now - t_last[i];
        e_req[i] = energy_add(e_req[i], dr);
        e_opt[i] = energy_add(e_opt[i], dop);
        if (timed[i]) begin
            if (on) begin
                t_min[i] = (t_min[i] > dt) ? t_min[i] - dt : 0;
                t_max[i] = (t_max[i] > dt) ? t_max[i] - dt : 0;
            end
        end else if (pwr[i] != 0) begin
            t_min[i] = wh_secs(e_req[i], pwr[i]);
            t_max[i] = wh_secs(e_opt[i], pwr[i]);
        end else begin
            t_min[i] = 0;
            t_max[i] = 0;
        end
        lft = left_of(t_end[i], now);
        if (t_max[i] < t_min[i]) t_max[i] = t_min[i];
        if (t_max[i] > lft) t_max[i] = lft;
        if (t_min[i] > t_max[i]) t_min[i] = t_max[i];
        if (t_max[i] == 0) wipe(i);
        t_last[i] = now;
        alive = used[i];
    endtask

    task automatic emit(logic [1:0] st, logic [2:0] sl, int p, logic [31:0] now);
        t_out_word w;
        w = '0;
        w.status = st;
        w.plan_slot = sl;
        if (p >= 0 && p < NP && used[p]) begin
            w.has_plan = 1;
            w.start_in = left_of(t_start[p], now);
            w.end_in = left_of(t_end[p], now);
            w.min_time = t_min[p];
            w.max_time = t_max[p];
        end
        batch.push_back(w);
    endtask

    task automatic predict_word(t_in_word c);
        int s;
        int best;
        logic alive;
        batch.delete();
        case (c.action)
            ACT_ALLOC_E, ACT_ALLOC_T, ACT_SET_E, ACT_SET_T: begin
                s = -1;
                if (c.action == ACT_ALLOC_E || c.action == ACT_ALLOC_T) begin
                    for (int i = NP - 1; i >= 0; i--) if (!used[i]) s = i;
                    if (s < 0) emit(STAT_NO_FREE, 0, -1, c.now);
                end else if (c.slot >= NP) begin
                    emit(STAT_BAD_SLOT, c.slot, -1, c.now);
                end else begin
                    s = c.slot;
                end
                if (s >= 0) begin
                    used[s] = 1;
                    timed[s] = (c.action == ACT_ALLOC_T || c.action == ACT_SET_T);
                    t_start[s] = c.earliest_start;
                    t_end[s] = c.latest_end;
                    pwr[s] = load_power;
                    e_req[s] = 0;
                    e_opt[s] = 0;
                    if (timed[s]) begin
                        t_min[s] = c.amount_a[31] ? 32'd0 : c.amount_a;
                        t_max[s] = c.amount_b[31] ? 32'd0 : c.amount_b;
                        refresh(s, c.now, 0, 0, 0, alive);
                    end else begin
                        refresh(s, c.now, 0, c.amount_a, c.amount_b, alive);
                    end
                    if (!load_on) act_valid = 0;
                    emit(STAT_OK, s, s, c.now);
                end
            end
            ACT_ADJUST: begin
                alive = 0;
                if (act_valid) refresh(act_idx, c.now, load_on, c.amount_a, c.amount_b, alive);
                if (alive) begin
                    emit(STAT_OK, act_idx, act_idx, c.now);
                end else begin
                    if (act_valid) begin
                        load_on = 0;
                        act_valid = 0;
                    end
                    emit(STAT_NO_ACTIVE, 0, -1, c.now);
                end
            end
            ACT_SELECT: begin
                if (act_valid) begin
                    refresh(act_idx, c.now, load_on, 0, 0, alive);
                    if (!alive) begin
                        load_on = 0;
                        act_valid = 0;
                    end
                end
                if (!act_valid) begin
                    best = -1;
                    for (int i = 0; i < NP; i++) begin
                        refresh(i, c.now, load_on, 0, 0, alive);
                        if (alive && (best < 0 || t_start[best] > t_start[i])) best = i;
                    end
                    if (best >= 0) begin
                        act_valid = 1;
                        act_idx = best;
                    end
                end
                if (act_valid) emit(STAT_OK, act_idx, act_idx, c.now);
                else emit(STAT_NO_ACTIVE, 0, -1, c.now);
            end
            ACT_REPORT: begin
                for (int i = 0; i < NP; i++) begin
                    if (used[i]) begin
                        refresh(i, c.now, load_on, 0, 0, alive);
                        if (alive) begin
                            if (batch.size() < RES_MAX) emit(STAT_OK, i, i, c.now);
                        end else if (act_valid && act_idx == i) begin
                            load_on = 0;
                            act_valid = 0;
                        end
                    end
                end
                if (batch.size() == 0) emit(STAT_OK, 0, -1, c.now);
            end
            ACT_CLEAR: begin
                if (c.slot >= NP) begin
                    emit(STAT_BAD_SLOT, c.slot, -1, c.now);
                end else begin
                    wipe(c.slot);
                    emit(STAT_OK, c.slot, -1, c.now);
                end
            end
            ACT_CLR_ALL: begin
                for (int i = 0; i < NP; i++) wipe(i);
                emit(STAT_OK, 0, -1, c.now);
            end
            ACT_SET_PWR: begin
                load_on = c.power_on;
                emit(STAT_OK, 0, -1, c.now);
            end
            default: emit(STAT_OK, 0, -1, c.now);
        endcase
        foreach (batch[k]) begin
            batch[k].power_state = load_on;
            batch[k].last = (k == batch.size() - 1);
            result_q.push_back(batch[k]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NP; i++) wipe(i);
            act_valid = 0;
            act_idx = 0;
            load_on = 0;
            load_power = 0;
            result_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else if (result_q[0] !== i_out_data) begin
                    $display("%0t: result mismatch expected %p actual %p",
                             $time, result_q[0], i_out_data);
                    o_errors <= o_errors + 1;
                    void'(result_q.pop_front());
                end else begin
                    void'(result_q.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) predict_word(i_in_data);
            if (i_cfg_valid && i_cfg_ready) load_power = i_cfg_data;
        end
        o_pending <= result_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule

/* test/energy_plan_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_plan_table_unit_tb
// drives directed and random plan commands and load power writes into the
// energy plan table with random gaps and result stalls; a checker beside the
// block predicts and compares every result word
// ----------------------------------------------------------------------------
module energy_plan_table_unit_tb;
    import epl_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    logic stall_free;

    epl_in_if  in_ch();
    epl_out_if out_ch();
    epl_cfg_if cfg_ch();

    energy_plan_table_unit #(.PLAN_COUNT(4)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    epl_checker #(.PLAN_COUNT(4)) u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_ready (in_ch.ready),
        .i_in_data  (in_ch.data),
        .i_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_out_data (out_ch.data),
        .i_cfg_valid(cfg_ch.valid),
        .i_cfg_ready(cfg_ch.ready),
        .i_cfg_data (cfg_ch.data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial begin
        #300ms;
        $display("TEST FAILED");
        $finish;
    end

    // result stall
    initial begin
        int w;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            w = stall_free ? 0 : $urandom_range(0, 13);
            if (w == 0 || (out_ch.valid && out_ch.ready)) begin
                out_ch.ready <= (w == 0) ? 1'b1 : 1'b0;
            end
            repeat (w) @(posedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            out_ch.ready <= 1'b0;
        end
    end

    task automatic send_word(t_in_word c);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 13);
        repeat (gap) @(posedge i_clk);
        in_ch.data <= c;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        in_ch.valid <= 1'b0;
    endtask

    task automatic write_power(logic [15:0] p);
        while (pending != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
        cfg_ch.data <= p;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(logic [3:0] act, logic [31:0] now);
        t_in_word c;
        c.action = act;
        c.now = now;
        c.slot = $urandom_range(0, 7);
        c.amount_a = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 5000);
        c.amount_b = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20000);
        c.earliest_start = now + $urandom_range(0, 3000) - 500;
        c.latest_end = $urandom_range(0, 7) == 0 ? $urandom() : now + $urandom_range(0, 90000);
        c.power_on = $urandom_range(0, 1);
        return c;
    endfunction

    initial begin
        t_in_word c;
        logic [31:0] clock_s;
        logic [15:0] powers [4];
        int pick;
        powers = '{16'd0, 16'hFFFF, 16'd1, 16'd2000};
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        stall_free = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero power first, then extremes
        clock_s = 32'd1000;
        c = make_word(ACT_ALLOC_E, clock_s);
        c.amount_a = 100; c.amount_b = 200; c.latest_end = 32'd5000;
        send_word(c);
        c = make_word(ACT_REPORT, clock_s);
        send_word(c);
        write_power(16'hFFFF);
        c = make_word(ACT_ALLOC_E, clock_s);
        c.amount_a = 32'sh7FFF_FFFF; c.amount_b = 32'sh8000_0000;
        c.earliest_start = '1; c.latest_end = '1;
        send_word(c);
        write_power(16'd1);
        c = make_word(ACT_ALLOC_E, 0);
        c.amount_a = 32'sh7FFF_FFFF; c.amount_b = 32'sh7FFF_FFFF;
        c.earliest_start = 0; c.latest_end = '1;
        send_word(c);
        c = make_word(ACT_ALLOC_T, 32'hFFFF_FFFF);
        c.amount_a = -5; c.amount_b = -1; c.latest_end = 0;
        send_word(c);
        c = make_word(ACT_ALLOC_T, clock_s);
        c.amount_a = 50; c.amount_b = 10; c.latest_end = clock_s + 40;
        send_word(c);
        c = make_word(ACT_ALLOC_T, clock_s);
        c.amount_a = 500; c.amount_b = 900; c.latest_end = clock_s + 2000;
        send_word(c);
        c = make_word(ACT_ALLOC_T, clock_s);
        send_word(c);
        c = make_word(ACT_ADJUST, clock_s);
        send_word(c);
        c = make_word(ACT_SET_PWR, clock_s); c.power_on = 1;
        send_word(c);
        c = make_word(ACT_SELECT, clock_s + 10);
        send_word(c);
        c = make_word(ACT_ADJUST, clock_s + 20);
        c.amount_a = 32'sh8000_0000; c.amount_b = 32'sh7FFF_FFFF;
        send_word(c);
        c = make_word(ACT_REPORT, clock_s + 60);
        send_word(c);
        c = make_word(ACT_SET_T, clock_s); c.slot = 3'd7;
        send_word(c);
        c = make_word(ACT_SET_E, clock_s); c.slot = 3'd4;
        send_word(c);
        c = make_word(ACT_CLEAR, clock_s); c.slot = 3'd5;
        send_word(c);
        c = make_word(ACT_CLEAR, clock_s); c.slot = 3'd0;
        send_word(c);
        c = make_word(4'd15, clock_s);
        send_word(c);
        c = make_word(ACT_CLR_ALL, clock_s);
        send_word(c);
        c = make_word(ACT_SELECT, clock_s);
        send_word(c);
        c = make_word(ACT_SET_PWR, clock_s); c.power_on = 0;
        send_word(c);

        // random: bursts of realistic plan traffic with advancing time
        for (int n = 0; n < 110; n++) begin
            if (n % 25 == 0) write_power(n == 50 ? 16'd0 : powers[$urandom_range(1, 3)]);
            if (n % 30 == 10) begin
                stall_free = 1'b1;
            end else if (n % 30 == 20) begin
                stall_free = 1'b0;
            end
            clock_s = clock_s + $urandom_range(0, 400);
            pick = $urandom_range(0, 19);
            if (pick < 4) c = make_word(ACT_ALLOC_E, clock_s);
            else if (pick < 7) c = make_word(ACT_ALLOC_T, clock_s);
            else if (pick < 8) c = make_word(ACT_SET_E, clock_s);
            else if (pick < 9) c = make_word(ACT_SET_T, clock_s);
            else if (pick < 11) c = make_word(ACT_ADJUST, clock_s);
            else if (pick < 13) c = make_word(ACT_SELECT, clock_s);
            else if (pick < 15) c = make_word(ACT_REPORT, clock_s);
            else if (pick < 16) c = make_word(ACT_CLEAR, clock_s);
            else if (pick < 17) c = make_word(ACT_SET_PWR, clock_s);
            else if (pick < 18) c = make_word($urandom_range(0, 15), $urandom());
            else if (pick < 19) begin
                c = make_word(ACT_ADJUST, clock_s);
                c.amount_a = $urandom(); c.amount_b = $urandom();
            end else begin
                c = make_word(ACT_CLR_ALL, clock_s);
            end
            send_word(c);
        end

        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
